[hw/rtl/srs_pkg.sv]
// Shared types and constants for the servo recipe sequencer.
`timescale 1ns / 1ps
`default_nettype none

package srs_pkg;

    localparam int SRS_RECIPE_DEPTH = 32;

    localparam int POS_W   = 5;
    localparam int WAIT_W  = 6;
    localparam int LOOP_W  = 5;
    localparam int FAULT_W = 2;
    localparam int STEP_W  = 5;
    localparam int WORD_W  = 8;
    localparam int ADDR_W  = 5;

    localparam logic [1:0] KIND_TICK     = 2'd0;
    localparam logic [1:0] KIND_OPERATOR = 2'd1;
    localparam logic [1:0] KIND_WRITE    = 2'd2;

    localparam logic [7:0] OPB_PAUSE_UC    = 8'd80;
    localparam logic [7:0] OPB_PAUSE_LC    = 8'd112;
    localparam logic [7:0] OPB_CONTINUE_UC = 8'd67;
    localparam logic [7:0] OPB_CONTINUE_LC = 8'd99;
    localparam logic [7:0] OPB_RIGHT_UC    = 8'd82;
    localparam logic [7:0] OPB_RIGHT_LC    = 8'd114;
    localparam logic [7:0] OPB_LEFT_UC     = 8'd76;
    localparam logic [7:0] OPB_LEFT_LC     = 8'd108;
    localparam logic [7:0] OPB_RESTART_UC  = 8'd66;
    localparam logic [7:0] OPB_RESTART_LC  = 8'd98;

    localparam logic [POS_W-1:0] POS_NUDGE_MAX = 5'd4;

    localparam logic [FAULT_W-1:0] FAULT_NONE   = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_LOOP   = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_OPCODE = 2'd2;

    localparam logic [WAIT_W-1:0] WAIT_MAX = 6'd62;

    typedef enum logic [2:0] {
        MODE_BEGIN = 3'd0,
        MODE_RUN   = 3'd1,
        MODE_PAUSE = 3'd2,
        MODE_END   = 3'd3,
        MODE_ERROR = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        OP_END        = 3'd0,
        OP_MOVE       = 3'd1,
        OP_WAIT       = 3'd2,
        OP_LOOP_START = 3'd4,
        OP_LOOP_END   = 3'd5
    } opcode_t;

    typedef struct packed {
        logic [POS_W-1:0]   servo_position;
        mode_t              run_status;
        logic [FAULT_W-1:0] fault_code;
        logic [STEP_W-1:0]  step_index;
    } srs_status_t;

endpackage

`default_nettype wire

[hw/rtl/srs_if.sv]
// Handshake channels for input words and result words.
`timescale 1ns / 1ps
`default_nettype none

interface srs_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] operator_byte;
    logic [4:0] recipe_addr;
    logic [7:0] recipe_word;

    modport source (output valid, output kind, output operator_byte,
                    output recipe_addr, output recipe_word, input ready);
    modport sink   (input valid, input kind, input operator_byte,
                    input recipe_addr, input recipe_word, output ready);
endinterface

interface srs_result_if;
    logic       valid;
    logic       ready;
    logic [4:0] servo_position;
    logic [2:0] run_status;
    logic [1:0] fault_code;
    logic [4:0] step_index;

    modport source (output valid, output servo_position, output run_status,
                    output fault_code, output step_index, input ready);
    modport sink   (input valid, input servo_position, input run_status,
                    input fault_code, input step_index, output ready);
endinterface

`default_nettype wire

[hw/rtl/srs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module srs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
)(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[hw/rtl/servo_recipe_sequencer.sv]
// Servo recipe sequencer: recipe store, command interpreter and result buffer.
//
// Takes one word per clock cycle while ready is high: a control tick, an
// operator byte or a recipe store write. Every word yields exactly one result
// word, the sequencer state after that word, registered into the buffer.
// Results pass through a two-entry buffer, so the input keeps flowing while
// one result waits; ready drops only when both entries are full. The recipe
// sits in a RAM with registered read that is always fetching the command at
// the next step index, so a tick executes in the cycle it arrives; a write
// to that very entry is forwarded. Errors stick until reset.
`timescale 1ns / 1ps
`default_nettype none

module servo_recipe_sequencer
    import srs_pkg::*;
#(
    parameter int RECIPE_DEPTH = SRS_RECIPE_DEPTH
)(
    input  logic         clk,
    input  logic         rst_n,
    srs_item_if.sink     item,
    srs_result_if.source result
);

    localparam int IDX_W = $clog2(RECIPE_DEPTH);
    localparam int CMP_W = (IDX_W + 1 > ADDR_W) ? IDX_W + 1 : ADDR_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RECIPE_DEPTH - 1);

    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [WAIT_W-1:0]  wait_reg, wait_next;
    logic [LOOP_W-1:0]  loop_rem_reg, loop_rem_next;
    logic [IDX_W-1:0]   loop_ret_reg, loop_ret_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    mode_t              mode_reg, mode_next;
    logic [FAULT_W-1:0] fault_reg, fault_next;

    logic               byp_valid_reg, byp_valid_next;
    logic [WORD_W-1:0]  byp_word_reg;

    logic               main_valid_reg, main_valid_next;
    srs_status_t        main_reg, main_next;
    logic               skid_valid_reg, skid_valid_next;
    srs_status_t        skid_reg, skid_next;

    logic               accept;
    logic               wr_in_range;
    logic               wr_en;
    logic [WORD_W-1:0]  ram_rd;
    logic [WORD_W-1:0]  cmd_word;
    opcode_t            op;
    logic [POS_W-1:0]   arg;
    logic [IDX_W-1:0]   idx_inc;
    logic [POS_W-1:0]   pos_diff;
    logic               pop;
    srs_status_t        new_status;

    assign accept      = item.valid && item.ready;
    assign wr_in_range = CMP_W'(item.recipe_addr) < CMP_W'(RECIPE_DEPTH);
    assign wr_en       = accept && (item.kind == KIND_WRITE) && wr_in_range;

    srs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RECIPE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (IDX_W'(item.recipe_addr)),
        .wr_data (item.recipe_word),
        .rd_addr (idx_next),
        .rd_data (ram_rd)
    );

    // forward a write that lands on the entry being prefetched
    assign byp_valid_next = wr_en && (IDX_W'(item.recipe_addr) == idx_next);

    assign cmd_word = byp_valid_reg ? byp_word_reg : ram_rd;
    assign op       = opcode_t'(cmd_word[7:5]);
    assign arg      = cmd_word[4:0];
    assign idx_inc  = (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;
    assign pos_diff = (pos_reg > arg) ? pos_reg - arg : arg - pos_reg;

    always_comb
    begin
        idx_next      = idx_reg;
        wait_next     = wait_reg;
        loop_rem_next = loop_rem_reg;
        loop_ret_next = loop_ret_reg;
        pos_next      = pos_reg;
        mode_next     = mode_reg;
        fault_next    = fault_reg;
        if (accept)
        begin
            unique case (item.kind)
                KIND_TICK:
                begin
                    if (mode_reg == MODE_RUN)
                    begin
                        if (wait_reg != '0)
                        begin
                            wait_next = wait_reg - 1'b1;
                        end
                        else
                        begin
                            unique case (op)
                                OP_MOVE:
                                begin
                                    wait_next = {pos_diff, 1'b0};
                                    pos_next  = arg;
                                    idx_next  = idx_inc;
                                end
                                OP_WAIT:
                                begin
                                    wait_next = WAIT_W'(arg);
                                    idx_next  = idx_inc;
                                end
                                OP_LOOP_START:
                                begin
                                    if (loop_rem_reg != '0)
                                    begin
                                        mode_next  = MODE_ERROR;
                                        fault_next = FAULT_LOOP;
                                    end
                                    loop_rem_next = arg;
                                    loop_ret_next = idx_inc;
                                    idx_next      = idx_inc;
                                end
                                OP_LOOP_END:
                                begin
                                    if (loop_rem_reg != '0)
                                    begin
                                        loop_rem_next = loop_rem_reg - 1'b1;
                                        if (loop_rem_reg != LOOP_W'(1))
                                        begin
                                            idx_next = loop_ret_reg;
                                        end
                                    end
                                    else
                                    begin
                                        idx_next = idx_inc;
                                    end
                                end
                                OP_END:
                                begin
                                    mode_next = MODE_END;
                                end
                                default:
                                begin
                                    mode_next  = MODE_ERROR;
                                    fault_next = FAULT_OPCODE;
                                end
                            endcase
                        end
                    end
                end
                KIND_OPERATOR:
                begin
                    if (mode_reg != MODE_ERROR)
                    begin
                        unique case (item.operator_byte) inside
                            OPB_PAUSE_UC, OPB_PAUSE_LC:
                            begin
                                mode_next = MODE_PAUSE;
                            end
                            OPB_CONTINUE_UC, OPB_CONTINUE_LC:
                            begin
                                if (mode_reg != MODE_END)
                                begin
                                    mode_next = MODE_RUN;
                                end
                            end
                            OPB_RIGHT_UC, OPB_RIGHT_LC:
                            begin
                                if (mode_reg == MODE_PAUSE && pos_reg != '0)
                                begin
                                    pos_next = pos_reg - 1'b1;
                                end
                            end
                            OPB_LEFT_UC, OPB_LEFT_LC:
                            begin
                                if (mode_reg == MODE_PAUSE && pos_reg <= POS_NUDGE_MAX)
                                begin
                                    pos_next = pos_reg + 1'b1;
                                end
                            end
                            OPB_RESTART_UC, OPB_RESTART_LC:
                            begin
                                idx_next      = '0;
                                wait_next     = '0;
                                loop_rem_next = '0;
                                pos_next      = '0;
                                fault_next    = FAULT_NONE;
                                mode_next     = MODE_RUN;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        new_status.servo_position = pos_next;
        new_status.run_status     = mode_next;
        new_status.fault_code     = fault_next;
        new_status.step_index     = STEP_W'(idx_next);
    end

    // two-entry result buffer
    assign pop        = main_valid_reg && result.ready;
    assign item.ready = !skid_valid_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_next       = main_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_next       = skid_reg;
                skid_valid_next = accept;
                skid_next       = new_status;
            end
            else
            begin
                main_valid_next = accept;
                main_next       = new_status;
            end
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_next       = new_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            wait_reg       <= '0;
            loop_rem_reg   <= '0;
            loop_ret_reg   <= '0;
            pos_reg        <= '0;
            mode_reg       <= MODE_BEGIN;
            fault_reg      <= FAULT_NONE;
            byp_valid_reg  <= 1'b0;
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg        <= idx_next;
            wait_reg       <= wait_next;
            loop_rem_reg   <= loop_rem_next;
            loop_ret_reg   <= loop_ret_next;
            pos_reg        <= pos_next;
            mode_reg       <= mode_next;
            fault_reg      <= fault_next;
            byp_valid_reg  <= byp_valid_next;
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byp_word_reg <= item.recipe_word;
        main_reg     <= main_next;
        skid_reg     <= skid_next;
    end

    assign result.valid          = main_valid_reg;
    assign result.servo_position = main_reg.servo_position;
    assign result.run_status     = main_reg.run_status;
    assign result.fault_code     = main_reg.fault_code;
    assign result.step_index     = main_reg.step_index;

    a_fault_iff_error: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_ERROR) == (fault_reg != FAULT_NONE))
        else $error("fault code and error mode disagree");

    a_error_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_ERROR) |=> (mode_reg == MODE_ERROR))
        else $error("error mode left without reset");

    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("buffer second entry filled ahead of first");

    a_wait_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wait_reg <= WAIT_MAX)
        else $error("wait count beyond largest move");

endmodule

`default_nettype wire
